/* src/spms_pkg.sv */
// shared constants, types and sequencer states for the sorted pair median search
package spms_pkg;

	localparam int MAX_LEN = 1024;
	localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int DATA_W  = 32;
	localparam int WIDE_W  = DATA_W + 1;

	// end-of-list stand-ins, one below and one above every 32-bit element
	localparam logic signed [WIDE_W-1:0] LOW_GUARD  = 33'sh1_7FFF_FFFF;
	localparam logic signed [WIDE_W-1:0] HIGH_GUARD = 33'sh0_8000_0000;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DROPPED = 2'd1;
	localparam logic [1:0] STATUS_NO_PART = 2'd2;

	localparam logic LIST_A = 1'b0;
	localparam logic LIST_B = 1'b1;

	typedef enum logic [2:0] {
		SRCH_IDLE,
		SRCH_SETUP,
		SRCH_MID,
		SRCH_READ,
		SRCH_CMP,
		SRCH_PICK,
		SRCH_OUT
	} srch_state_t;

	// load side to search side
	typedef struct packed {
		logic             launch;
		logic [CNT_W-1:0] count_a;
		logic [CNT_W-1:0] count_b;
	} load_info_t;

	// read addresses for the short and the long list, two taps each
	typedef struct packed {
		logic              swap;
		logic [ADDR_W-1:0] short_lo;
		logic [ADDR_W-1:0] short_hi;
		logic [ADDR_W-1:0] long_lo;
		logic [ADDR_W-1:0] long_hi;
	} rd_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] short_lo;
		logic [DATA_W-1:0] short_hi;
		logic [DATA_W-1:0] long_lo;
		logic [DATA_W-1:0] long_hi;
	} rd_data_t;

	typedef struct packed {
		logic                     valid;
		logic                     fail;
		logic signed [WIDE_W-1:0] twice;
	} res_t;

endpackage

/* src/spms_store.sv */
// element storage for both lists, one write port and two read taps per list
module spms_store (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic                           wr_sel,
	input  logic [spms_pkg::ADDR_W-1:0]    wr_addr,
	input  logic [spms_pkg::DATA_W-1:0]    wr_data,
	input  spms_pkg::rd_req_t              rd,
	output spms_pkg::rd_data_t             rdata
);

	logic [spms_pkg::DATA_W-1:0] mem_a [spms_pkg::MAX_LEN];
	logic [spms_pkg::DATA_W-1:0] mem_b [spms_pkg::MAX_LEN];

	logic [spms_pkg::ADDR_W-1:0] a0_addr, a1_addr, b0_addr, b1_addr;
	logic [spms_pkg::DATA_W-1:0] a0_q, a1_q, b0_q, b1_q;

	// list a is the short list unless swapped
	assign a0_addr = rd.swap ? rd.long_lo  : rd.short_lo;
	assign a1_addr = rd.swap ? rd.long_hi  : rd.short_hi;
	assign b0_addr = rd.swap ? rd.short_lo : rd.long_lo;
	assign b1_addr = rd.swap ? rd.short_hi : rd.long_hi;

	always_ff @(posedge clk) begin
		if (wr_en && (wr_sel == spms_pkg::LIST_A)) begin
			mem_a[wr_addr] <= wr_data;
		end
		a0_q <= mem_a[a0_addr];
		a1_q <= mem_a[a1_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_sel == spms_pkg::LIST_B)) begin
			mem_b[wr_addr] <= wr_data;
		end
		b0_q <= mem_b[b0_addr];
		b1_q <= mem_b[b1_addr];
	end

	assign rdata.short_lo = rd.swap ? b0_q : a0_q;
	assign rdata.short_hi = rd.swap ? b1_q : a1_q;
	assign rdata.long_lo  = rd.swap ? a0_q : b0_q;
	assign rdata.long_hi  = rd.swap ? a1_q : b1_q;

endmodule

/* src/spms_search.sv */
// partition search sequencer with its shared compare datapath
module spms_search (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spms_pkg::load_info_t  ld,
	input  spms_pkg::rd_data_t    rdata,
	output spms_pkg::rd_req_t     rd,
	output spms_pkg::res_t        res,
	output logic                  busy
);

	localparam int CW = spms_pkg::CNT_W;
	localparam int WW = spms_pkg::WIDE_W;

	spms_pkg::srch_state_t state_q, state_d;

	logic              swap_q;
	logic [CW-1:0]     ns_q, nl_q, half_q;
	logic              odd_q, fail_q;
	logic signed [CW:0] lo_q, hi_q;
	logic [CW-1:0]     c1_q, c2_q;
	logic              l1_ok_q, r1_ok_q, l2_ok_q, r2_ok_q;
	logic signed [WW-1:0] left_q, right_q;

	logic              swap_d;
	logic [CW-1:0]     ns_d, nl_d;
	logic [CW:0]       total_d;
	logic [CW+1:0]     total_p1;
	logic [CW:0]       mid_sum;
	logic [CW-1:0]     c1_d;
	logic [CW-1:0]     c1_m1, c2_m1;
	logic signed [WW-1:0] l1, r1, l2, r2;
	logic              l1_le_r2, l2_le_r1;
	logic signed [WW:0] twice_w;

	// setup arithmetic
	assign swap_d   = ld.count_a > ld.count_b;
	assign ns_d     = swap_d ? ld.count_b : ld.count_a;
	assign nl_d     = swap_d ? ld.count_a : ld.count_b;
	assign total_d  = {1'b0, ld.count_a} + {1'b0, ld.count_b};
	assign total_p1 = {1'b0, total_d} + {{(CW+1){1'b0}}, 1'b1};

	// lo and hi are both non-negative whenever the midpoint is taken
	assign mid_sum = {1'b0, lo_q[CW-1:0]} + {1'b0, hi_q[CW-1:0]};
	assign c1_d    = mid_sum[CW:1];

	assign c1_m1 = c1_q - {{(CW-1){1'b0}}, 1'b1};
	assign c2_m1 = c2_q - {{(CW-1){1'b0}}, 1'b1};

	assign rd.swap     = swap_q;
	assign rd.short_lo = c1_m1[spms_pkg::ADDR_W-1:0];
	assign rd.short_hi = c1_q[spms_pkg::ADDR_W-1:0];
	assign rd.long_lo  = c2_m1[spms_pkg::ADDR_W-1:0];
	assign rd.long_hi  = c2_q[spms_pkg::ADDR_W-1:0];

	// neighbors with guards past either end
	assign l1 = l1_ok_q ? $signed({rdata.short_lo[31], rdata.short_lo}) : spms_pkg::LOW_GUARD;
	assign r1 = r1_ok_q ? $signed({rdata.short_hi[31], rdata.short_hi}) : spms_pkg::HIGH_GUARD;
	assign l2 = l2_ok_q ? $signed({rdata.long_lo[31], rdata.long_lo}) : spms_pkg::LOW_GUARD;
	assign r2 = r2_ok_q ? $signed({rdata.long_hi[31], rdata.long_hi}) : spms_pkg::HIGH_GUARD;

	assign l1_le_r2 = l1 <= r2;
	assign l2_le_r1 = l2 <= r1;

	assign twice_w = odd_q ? ($signed({left_q[WW-1], left_q}) <<< 1)
	                       : ($signed({left_q[WW-1], left_q}) + $signed({right_q[WW-1], right_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spms_pkg::SRCH_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		res.valid = 1'b0;
		res.fail  = fail_q;
		res.twice = twice_w[WW-1:0];
		case (state_q)
			spms_pkg::SRCH_IDLE: begin
				busy = 1'b0;
				if (ld.launch) begin
					state_d = spms_pkg::SRCH_SETUP;
				end
			end
			spms_pkg::SRCH_SETUP: begin
				state_d = (total_d == '0) ? spms_pkg::SRCH_OUT : spms_pkg::SRCH_MID;
			end
			spms_pkg::SRCH_MID: begin
				state_d = (lo_q > hi_q) ? spms_pkg::SRCH_OUT : spms_pkg::SRCH_READ;
			end
			spms_pkg::SRCH_READ: begin
				state_d = spms_pkg::SRCH_CMP;
			end
			spms_pkg::SRCH_CMP: begin
				state_d = (l1_le_r2 && l2_le_r1) ? spms_pkg::SRCH_PICK : spms_pkg::SRCH_MID;
			end
			spms_pkg::SRCH_PICK: begin
				state_d = spms_pkg::SRCH_OUT;
			end
			spms_pkg::SRCH_OUT: begin
				res.valid = 1'b1;
				state_d   = spms_pkg::SRCH_IDLE;
			end
			default: begin
				state_d = spms_pkg::SRCH_IDLE;
			end
		endcase
	end

	// search registers
	always_ff @(posedge clk) begin
		case (state_q)
			spms_pkg::SRCH_SETUP: begin
				swap_q <= swap_d;
				ns_q   <= ns_d;
				nl_q   <= nl_d;
				half_q <= total_p1[CW:1];
				odd_q  <= total_d[0];
				lo_q   <= '0;
				hi_q   <= $signed({1'b0, ns_d});
				fail_q <= (total_d == '0);
			end
			spms_pkg::SRCH_MID: begin
				c1_q <= c1_d;
				c2_q <= half_q - c1_d;
				if (lo_q > hi_q) begin
					fail_q <= 1'b1;
				end
			end
			spms_pkg::SRCH_READ: begin
				l1_ok_q <= (c1_q != '0);
				r1_ok_q <= (c1_q < ns_q);
				l2_ok_q <= (c2_q != '0);
				r2_ok_q <= (c2_q < nl_q);
			end
			spms_pkg::SRCH_CMP: begin
				if (!l1_le_r2) begin
					hi_q <= $signed({1'b0, c1_q}) - $signed({{CW{1'b0}}, 1'b1});
				end else if (!l2_le_r1) begin
					lo_q <= $signed({1'b0, c1_q}) + $signed({{CW{1'b0}}, 1'b1});
				end
			end
			spms_pkg::SRCH_PICK: begin
				left_q  <= (l1 > l2) ? l1 : l2;
				right_q <= (r1 < r2) ? r1 : r2;
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/sorted_pair_median_search.sv */
// top level: element loading, list counts, drop tracking and result register
//
// Median of two ascending lists of signed 32-bit elements. Each beat taken on
// start (while busy is low) appends value to list A (target_list 0) or list B
// (target_list 1); busy stays low after a plain element, so elements may
// stream in back to back. A beat with last set is stored like any other and
// then starts a binary search over the cut in the shorter list. Busy stays
// high from setup until the result is out; the search takes k steps, at most
// floor(log2(min(count_a, count_b) + 1)) + 1 (11 with 1024 entries); each
// step passes through a midpoint state, a memory read state and a compare
// state. An empty set goes from setup straight to the result. The result
// appears on median_twice and status, flagged by done for exactly one
// cycle, in the cycle busy falls; it cannot be held off, so the receiver
// must take it then. median_twice is twice the median (the sum
// of the two middle elements for an even total). status reads ok, dropped
// (some elements found their list holding 1024 entries and were discarded),
// or no partition (unsorted input or empty set; median_twice is then 0).
// No partition wins over dropped. Both lists empty out after each result.
module sorted_pair_median_search (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               target_list,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               done,
	output logic signed [32:0] median_twice,
	output logic [1:0]         status
);

	localparam int CW = spms_pkg::CNT_W;

	logic [CW-1:0] count_a_q, count_b_q;
	logic          dropped_q;
	logic          done_q;
	logic signed [32:0] median_twice_q;
	logic [1:0]    status_q;

	logic          accept;
	logic          list_full;
	logic          wr_en;
	logic [CW-1:0] wr_count;

	spms_pkg::load_info_t ld;
	spms_pkg::rd_req_t    rd;
	spms_pkg::rd_data_t   rdata;
	spms_pkg::res_t       res;

	// beat handshake
	assign accept = start && !busy;

	// a full list silently drops the beat and marks the set
	assign wr_count  = (target_list == spms_pkg::LIST_B) ? count_b_q : count_a_q;
	assign list_full = (wr_count == CW'(spms_pkg::MAX_LEN));
	assign wr_en     = accept && !list_full;

	assign ld.launch  = accept && last;
	assign ld.count_a = count_a_q;
	assign ld.count_b = count_b_q;

	spms_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_sel  (target_list),
		.wr_addr (wr_count[spms_pkg::ADDR_W-1:0]),
		.wr_data (value),
		.rd      (rd),
		.rdata   (rdata)
	);

	spms_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.rdata  (rdata),
		.rd     (rd),
		.res    (res),
		.busy   (busy)
	);

	// counts and drop flag; cleared as the result leaves the search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
			dropped_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= res.valid;
			if (res.valid) begin
				count_a_q <= '0;
				count_b_q <= '0;
				dropped_q <= 1'b0;
			end else if (accept) begin
				if (list_full) begin
					dropped_q <= 1'b1;
				end else if (target_list == spms_pkg::LIST_B) begin
					count_b_q <= count_b_q + {{(CW-1){1'b0}}, 1'b1};
				end else begin
					count_a_q <= count_a_q + {{(CW-1){1'b0}}, 1'b1};
				end
			end
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (res.valid) begin
			if (res.fail) begin
				median_twice_q <= '0;
				status_q       <= spms_pkg::STATUS_NO_PART;
			end else begin
				median_twice_q <= res.twice;
				status_q       <= dropped_q ? spms_pkg::STATUS_DROPPED : spms_pkg::STATUS_OK;
			end
		end
	end

	assign done         = done_q;
	assign median_twice = median_twice_q;
	assign status       = status_q;

	// a result only ever closes a search
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a search");

	// a failed search reports zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == spms_pkg::STATUS_NO_PART)) |-> (median_twice == '0))
		else $error("no-partition result carries a value");

	// status is one of the defined codes on a result beat
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status == spms_pkg::STATUS_OK) || (status == spms_pkg::STATUS_DROPPED)
			|| (status == spms_pkg::STATUS_NO_PART)))
		else $error("undefined status code");

	// lists never grow past capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_a_q <= CW'(spms_pkg::MAX_LEN)) && (count_b_q <= CW'(spms_pkg::MAX_LEN)))
		else $error("list count beyond capacity");

	// lists are empty once a result has gone out
	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((count_a_q == '0) && (count_b_q == '0) && !dropped_q))
		else $error("set not cleared after result");

endmodule
